// ===== rtl/bqat_pkg.sv =====
// ----------------------------------------------------------------------------
// bqat_pkg
// Types and constants shared by the quote- and bracket-aware tokenizer.
// ----------------------------------------------------------------------------
package bqat_pkg;

  // Byte codes that the scanner treats specially.
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChLCurly  = 8'h7B;
  localparam logic [7:0] ChRCurly  = 8'h7D;
  localparam logic [7:0] ChLSquare = 8'h5B;
  localparam logic [7:0] ChRSquare = 8'h5D;

  // Item kinds.
  localparam logic KindChar = 1'b0;
  localparam logic KindEos  = 1'b1;

  // Register map.
  localparam int unsigned AddrW       = 3;
  localparam logic        RegSeparator = 1'b0;
  localparam logic [7:0]  SepReset    = 8'd44;

  localparam int unsigned MaxDepthDefault = 255;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] char_out;
    logic       token_end;
    logic       string_end;
  } out_item_t;

endpackage

// ===== rtl/bqat_core.sv =====
// ----------------------------------------------------------------------------
// bqat_core
// Scanner state (quote, escape, nesting depths) and the per-byte decision.
// ----------------------------------------------------------------------------
module bqat_core #(
  parameter int unsigned MaxDepth = bqat_pkg::MaxDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bqat_pkg::in_item_t item_i,
  input  logic [7:0]         separator_i,
  output bqat_pkg::out_item_t result_o
);
  import bqat_pkg::*;

  localparam int unsigned DepthW = $clog2(MaxDepth + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MaxDepth);

  logic              in_quote_q, in_quote_d;
  logic              escape_q, escape_d;
  logic [DepthW-1:0] curly_q, curly_d;
  logic [DepthW-1:0] square_q, square_d;
  logic              split;

  function automatic logic [DepthW-1:0] depth_up(input logic [DepthW-1:0] d);
    depth_up = (d < DepthMax) ? d + 1'b1 : DepthMax;
  endfunction

  function automatic logic [DepthW-1:0] depth_down(input logic [DepthW-1:0] d);
    depth_down = (d != '0) ? d - 1'b1 : '0;
  endfunction

  always_comb begin
    in_quote_d = in_quote_q;
    escape_d   = escape_q;
    curly_d    = curly_q;
    square_d   = square_q;
    split      = 1'b0;
    if (item_i.kind == KindEos) begin
      in_quote_d = 1'b0;
      escape_d   = 1'b0;
      curly_d    = '0;
      square_d   = '0;
    end else if (escape_q) begin
      escape_d = 1'b0;
    end else if (in_quote_q) begin
      if (item_i.char_in == ChBslash) begin
        escape_d = 1'b1;
      end else if (item_i.char_in == ChQuote) begin
        in_quote_d = 1'b0;
      end
    end else if (item_i.char_in == ChQuote) begin
      in_quote_d = 1'b1;
    end else if (item_i.char_in == ChLCurly) begin
      curly_d = depth_up(curly_q);
    end else if (item_i.char_in == ChRCurly) begin
      curly_d = depth_down(curly_q);
    end else if (item_i.char_in == ChLSquare) begin
      square_d = depth_up(square_q);
    end else if (item_i.char_in == ChRSquare) begin
      square_d = depth_down(square_q);
    end else if (item_i.char_in == separator_i && curly_q == '0 && square_q == '0) begin
      split = 1'b1;
    end
  end

  always_comb begin
    if (item_i.kind == KindEos) begin
      result_o = '{has_char: 1'b0, char_out: 8'd0, token_end: 1'b1, string_end: 1'b1};
    end else if (split) begin
      result_o = '{has_char: 1'b0, char_out: 8'd0, token_end: 1'b1, string_end: 1'b0};
    end else begin
      result_o = '{has_char: 1'b1, char_out: item_i.char_in, token_end: 1'b0,
                   string_end: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      escape_q   <= 1'b0;
      curly_q    <= '0;
      square_q   <= '0;
    end else if (step_i) begin
      in_quote_q <= in_quote_d;
      escape_q   <= escape_d;
      curly_q    <= curly_d;
      square_q   <= square_d;
    end
  end

endmodule

// ===== rtl/bracket_quote_aware_tokenizer.sv =====
// ----------------------------------------------------------------------------
// bracket_quote_aware_tokenizer
// Splits a byte stream into tokens at a programmable separator, honoring
// double quotes, backslash escapes inside quotes, and curly/square nesting.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o   in_item_i  (kind, char_in)
//   out      source     out_valid_o / out_stall_i out_item_o (has_char, char_out,
//                                                  token_end, string_end)
//   cfg      sink       APB (psel/penable/pwrite) separator at byte address 0
//
// One beat in, one beat out; a new beat is taken every cycle unless the
// output stalls. Beats pass through the input register, then scanner logic
// into the result register. Reset clears the scanner state and sets the
// separator to a comma. An output stall holds the result register and, once
// the input register is also full, raises in_stall_o in the same cycle.
// ----------------------------------------------------------------------------
module bracket_quote_aware_tokenizer #(
  parameter int unsigned MaxDepth = bqat_pkg::MaxDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bqat_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bqat_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bqat_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bqat_pkg::*;

  logic [7:0] separator_q;
  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  out_item_t  result;
  logic       out_load;
  logic       in_load;
  logic       cfg_write;

  // Register access: bit 2 of the byte address selects the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegSeparator);
  assign prdata    = (paddr[2] == RegSeparator) ? {24'd0, separator_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      separator_q <= SepReset;
    end else if (cfg_write) begin
      separator_q <= pwdata[7:0];
    end
  end

  // The result register takes a new beat when it is empty or being drained.
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  bqat_core #(
    .MaxDepth(MaxDepth)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (out_load),
    .item_i     (in_item_q),
    .separator_i(separator_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load || out_load) begin
        in_valid_q <= in_load;
      end
      if (out_load || !out_stall_i) begin
        out_valid_q <= out_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_item_q <= in_item_i;
    end
    if (out_load) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== verif/tb_bracket_quote_aware_tokenizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bracket_quote_aware_tokenizer
// Self-checking bench for the tokenizer. A scoreboard tracks quote, escape and
// nesting state for every accepted input beat and checks each output beat
// against its prediction. Stimulus runs a short directed string, a deep
// nesting run past the depth cap, then random strings under several separator
// settings. Input bursts, output stalls and one long output hold-off shake the
// handshakes.
// ----------------------------------------------------------------------------
module tb_bracket_quote_aware_tokenizer;
  import bqat_pkg::*;

  class token_scoreboard;
    localparam int unsigned DepthCap = MaxDepthDefault;

    logic [7:0]  separator;
    bit          in_quote;
    bit          escape_pending;
    int unsigned curly_depth;
    int unsigned square_depth;
    out_item_t   token_beats_q[$];
    int unsigned n_errors;

    function new();
      separator = SepReset;
      n_errors  = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      in_quote       = 1'b0;
      escape_pending = 1'b0;
      curly_depth    = 0;
      square_depth   = 0;
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // Predicts the output beat of one accepted input beat.
    function void accept_byte(in_item_t it);
      out_item_t  r;
      logic [7:0] c;
      c            = it.char_in;
      r.has_char   = 1'b1;
      r.char_out   = c;
      r.token_end  = 1'b0;
      r.string_end = 1'b0;
      if (it.kind == KindEos) begin
        clear_scan();
        r.has_char   = 1'b0;
        r.char_out   = 8'h00;
        r.token_end  = 1'b1;
        r.string_end = 1'b1;
      end else if (escape_pending) begin
        escape_pending = 1'b0;
      end else if (in_quote) begin
        if (c == ChBslash) escape_pending = 1'b1;
        else if (c == ChQuote) in_quote = 1'b0;
      end else if (c == ChQuote) begin
        in_quote = 1'b1;
      end else if (c == ChLCurly) begin
        if (curly_depth < DepthCap) curly_depth++;
      end else if (c == ChRCurly) begin
        if (curly_depth > 0) curly_depth--;
      end else if (c == ChLSquare) begin
        if (square_depth < DepthCap) square_depth++;
      end else if (c == ChRSquare) begin
        if (square_depth > 0) square_depth--;
      end else if (c == separator && curly_depth == 0 && square_depth == 0) begin
        r.has_char  = 1'b0;
        r.char_out  = 8'h00;
        r.token_end = 1'b1;
      end
      token_beats_q = {token_beats_q, r};
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (token_beats_q.size() == 0) begin
        flag($sformatf("output beat with nothing pending: has_char %b char_out %h %s %b %b",
                       got.has_char, got.char_out, "token_end/string_end",
                       got.token_end, got.string_end));
        return;
      end
      want = token_beats_q.pop_front();
      if (got.has_char !== want.has_char || got.char_out !== want.char_out ||
          got.token_end !== want.token_end || got.string_end !== want.string_end) begin
        flag($sformatf({"output beat differs: exp has_char %b char_out %h token_end %b ",
                        "string_end %b, got %b %h %b %b"},
                       want.has_char, want.char_out, want.token_end, want.string_end,
                       got.has_char, got.char_out, got.token_end, got.string_end));
      end
    endfunction

    function void check_reg(logic [31:0] got);
      if (got !== {24'd0, separator})
        flag($sformatf("separator readback: exp %h got %h", {24'd0, separator}, got));
    endfunction
  endclass

  localparam logic [AddrW-1:0] SepAddr = AddrW'(4 * RegSeparator);

  // Directed string, first beat in the top bits: plain bytes, splits, unmatched
  // closers, separators inside brackets and quotes, escapes, brackets inside
  // quotes, and an end of string that drops an open quote and a pending escape.
  localparam logic [27*9-1:0] DirTab = {
    {KindChar, 8'h00},     {KindChar, 8'hFF},     {KindChar, SepReset},
    {KindChar, ChRCurly},  {KindChar, ChRSquare}, {KindChar, SepReset},
    {KindChar, ChLCurly},  {KindChar, SepReset},  {KindChar, ChRCurly},
    {KindChar, ChLSquare}, {KindChar, SepReset},  {KindChar, ChRSquare},
    {KindChar, ChQuote},   {KindChar, SepReset},  {KindChar, ChBslash},
    {KindChar, ChQuote},   {KindChar, ChBslash},  {KindChar, ChBslash},
    {KindChar, ChLCurly},  {KindChar, ChQuote},   {KindChar, SepReset},
    {KindChar, ChBslash},  {KindChar, ChQuote},   {KindChar, ChBslash},
    {KindEos,  8'hFF},     {KindChar, SepReset},  {KindEos,  8'h00}
  };

  // Separator settings of the random phases; a last phase uses a random byte.
  localparam logic [8*8-1:0] SepPlan = {
    8'h00, 8'hFF, ChQuote, ChLCurly, ChRSquare, ChBslash, 8'h3B, SepReset
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  token_scoreboard sb;
  int unsigned     burst_left = 0;
  bit              no_gaps = 1'b0;
  int unsigned     hold_asked = 0;

  bracket_quote_aware_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.accept_byte(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_beat(out_item_o);
    end
  end

  // Holds the beat until the block takes it.
  task automatic send_beat(input in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic offer(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_beat(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.token_beats_q.size() != 0);
  endtask

  task automatic apb_access(input bit wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only the low byte is meant to land.
  task automatic set_separator(input logic [7:0] value);
    logic [31:0] wdata;
    logic [31:0] rdata;
    wdata       = $urandom;
    wdata[7:0]  = value;
    apb_access(1'b1, SepAddr, wdata, rdata);
    sb.separator = value;
    @(posedge clk_i);
    apb_access(1'b0, SepAddr, 32'd0, rdata);
    sb.check_reg(rdata);
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return sb.separator;
    if (r < 25) return ChQuote;
    if (r < 32) return ChBslash;
    if (r < 40) return ChLCurly;
    if (r < 48) return ChRCurly;
    if (r < 56) return ChLSquare;
    if (r < 64) return ChRSquare;
    if (r < 85) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom);
  endfunction

  // Mostly strings of meaningful bytes closed by an end of string; some are
  // raw noise with stray end-of-string beats mixed in.
  task automatic run_strings(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    bit          noisy;
    in_item_t    it;
    sent = 0;
    while (sent < n_items) begin
      noisy = ($urandom_range(0, 5) == 0);
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      repeat (len) begin
        it.kind    = (noisy && $urandom_range(0, 7) == 0) ? KindEos : KindChar;
        it.char_in = noisy ? 8'($urandom) : pick_byte();
        offer(it);
        sent++;
      end
      it.kind    = KindEos;
      it.char_in = 8'($urandom);
      offer(it);
      sent++;
    end
  endtask

  // Output side: random stall modes, plus a long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    mode_left   = 0;
    hold_left   = 0;
    hold_seen   = 0;
    mode        = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (mode_left % 8 < 3);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] rdata;
    logic [7:0]  sep;
    sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, SepAddr, 32'd0, rdata);
    sb.check_reg(rdata);

    for (int i = 0; i < 27; i++) offer(DirTab[(26 - i) * 9 +: 9]);

    // Nest past the cap on both kinds, then unwind exactly the cap: the
    // separator must split again only if the depths saturated.
    repeat (257) offer({KindChar, ChLCurly});
    repeat (257) offer({KindChar, ChLSquare});
    offer({KindChar, SepReset});
    repeat (255) offer({KindChar, ChRSquare});
    repeat (255) offer({KindChar, ChRCurly});
    offer({KindChar, SepReset});
    offer({KindChar, ChRSquare});
    offer({KindChar, ChRCurly});
    offer({KindChar, SepReset});
    offer({KindEos, 8'h00});
    drain();

    for (int p = 0; p < 9; p++) begin
      sep = (p < 8) ? SepPlan[(7 - p) * 8 +: 8] : 8'($urandom);
      set_separator(sep);
      if (p == 6) begin
        hold_asked++;
        no_gaps = 1'b1;
      end
      run_strings(25);
      no_gaps = 1'b0;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.token_beats_q.size() == 0) begin
      $display("bracket_quote_aware_tokenizer: match");
    end else begin
      $display("bracket_quote_aware_tokenizer: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("bracket_quote_aware_tokenizer: mismatch");
    $finish;
  end

endmodule
